### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the decoder core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that ante implies cons in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lzsswd_pkg.sv
// ---------------------------------------------------------------------------
// LZSS window decoder package
// Shared widths and format constants of the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package lzsswd_pkg;

  localparam int LZSSWD_WINDOW_SIZE = 4096;
  localparam int CNT_W              = 24;
  localparam int POS_W              = 12;
  localparam int RUN_W              = 5;

  localparam logic [POS_W-1:0] MATCH_BIAS = 12'h012;
  localparam logic [RUN_W-1:0] MIN_MATCH  = 5'd3;
  localparam logic [8:0]       FLAG_MARK  = 9'h100;

  typedef logic [CNT_W-1:0] count_t;

endpackage

`default_nettype wire

### rtl/lzsswd_ring.sv
// ---------------------------------------------------------------------------
// LZSS history ring
// Single write port, single registered read port byte memory.
// ---------------------------------------------------------------------------
`default_nettype none

module lzsswd_ring #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lzsswd_src.sv
// ---------------------------------------------------------------------------
// LZSS source address unit
// Shared subtractor: source position and in-stream check for a copy byte.
// ---------------------------------------------------------------------------
`default_nettype none

module lzsswd_src
  import lzsswd_pkg::*;
#(
  parameter int AW = 12
) (
  input  wire count_t        bytes_written,
  input  wire logic [AW:0]   back_dist,
  output logic      [AW-1:0] src_addr,
  output logic               src_hit
);

  logic [CNT_W:0] diff;

  assign diff     = {1'b0, bytes_written} - (CNT_W+1)'(back_dist);
  assign src_hit  = ~diff[CNT_W];
  assign src_addr = diff[AW-1:0];

endmodule

`default_nettype wire

### rtl/lzsswd_core.sv
// ---------------------------------------------------------------------------
// LZSS window decoder core
// Parse sequencer, output register and bookkeeping around ring and unit.
// ---------------------------------------------------------------------------
`default_nettype none

module lzsswd_core
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_SIZE = LZSSWD_WINDOW_SIZE
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic [0:0] in_tuser,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic [0:0]      out_tuser
);

`include "assert_macros.svh"

  localparam int AW = $clog2(WINDOW_SIZE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_ITEM  = 2'd1;
  localparam logic [1:0] PH_MHIGH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  count_t           bw_r, bw_nxt;
  count_t           len_r, len_nxt;
  logic [8:0]       flag_r, flag_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [AW:0]      dist_r, dist_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       lit_r, lit_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_end_r, out_end_nxt;

  logic             in_fire, start, slot_free, emit_go, done_run, end_hit;
  count_t           bw_eff, bw_inc;
  logic [8:0]       flag_eff, flag_adv;
  logic [1:0]       phase_eff, phase_adv;
  logic [7:0]       low_eff, wr_byte, rd_data;
  logic [AW-1:0]    pos, dist_lo, src_addr;
  logic             src_hit;

  lzsswd_src #(.AW(AW)) u_src (
    .bytes_written (bw_r),
    .back_dist     (dist_r),
    .src_addr      (src_addr),
    .src_hit       (src_hit)
  );

  lzsswd_ring #(.AW(AW)) u_ring (
    .clk       (clk),
    .wr_en     (emit_go),
    .wr_addr   (bw_r[AW-1:0]),
    .wr_data   (wr_byte),
    .rd_en     (state_r == S_RD),
    .rd_addr   (src_addr),
    .rd_data_r (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign start     = in_tuser[0];
  assign slot_free = ~out_valid_r | out_tready;

  assign bw_eff    = start ? '0 : bw_r;
  assign flag_eff  = start ? '0 : flag_r;
  assign phase_eff = start ? PH_FLAG : phase_r;
  assign low_eff   = start ? '0 : low_r;

  assign pos     = AW'({in_tdata[7:4], low_eff}) + AW'(MATCH_BIAS);
  assign dist_lo = bw_eff[AW-1:0] - pos;

  assign flag_adv  = flag_r >> 1;
  assign phase_adv = (flag_adv < 9'd2) ? PH_FLAG : PH_ITEM;

  assign emit_go  = ((state_r == S_LIT) || (state_r == S_EMIT)) && slot_free;
  assign bw_inc   = bw_r + 1'b1;
  assign end_hit  = (bw_inc == len_r);
  assign done_run = (state_r == S_LIT) || (cnt_r == RUN_W'(1)) || end_hit;
  assign wr_byte  = (state_r == S_LIT) ? lit_r : (hit_r ? rd_data : 8'h00);

  always_comb begin
    state_nxt     = state_r;
    bw_nxt        = bw_r;
    len_nxt       = len_r;
    flag_nxt      = flag_r;
    phase_nxt     = phase_r;
    low_nxt       = low_r;
    dist_nxt      = dist_r;
    cnt_nxt       = cnt_r;
    lit_nxt       = lit_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;

    if (cfg_wr_en) begin
      len_nxt = cfg_wr_data;
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          bw_nxt    = bw_eff;
          flag_nxt  = flag_eff;
          phase_nxt = phase_eff;
          low_nxt   = low_eff;
          if (bw_eff < len_r) begin
            case (phase_eff)
              PH_ITEM: begin
                if (flag_eff[0]) begin
                  lit_nxt   = in_tdata;
                  state_nxt = S_LIT;
                end else begin
                  low_nxt   = in_tdata;
                  phase_nxt = PH_MHIGH;
                end
              end
              PH_MHIGH: begin
                dist_nxt  = (dist_lo == '0) ? {1'b1, {AW{1'b0}}} : {1'b0, dist_lo};
                cnt_nxt   = {1'b0, in_tdata[3:0]} + MIN_MATCH;
                state_nxt = S_RD;
              end
              default: begin
                flag_nxt  = {1'b0, in_tdata} | FLAG_MARK;
                phase_nxt = PH_ITEM;
              end
            endcase
          end
        end
      end
      S_RD: begin
        hit_nxt   = src_hit;
        state_nxt = S_EMIT;
      end
      S_LIT, S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = wr_byte;
          out_last_nxt  = done_run;
          out_end_nxt   = end_hit;
          bw_nxt        = bw_inc;
          cnt_nxt       = cnt_r - 1'b1;
          if (done_run) begin
            flag_nxt  = flag_adv;
            phase_nxt = phase_adv;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bw_r        <= '0;
      len_r       <= '0;
      flag_r      <= '0;
      phase_r     <= PH_FLAG;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bw_r        <= bw_nxt;
      len_r       <= len_nxt;
      flag_r      <= flag_nxt;
      phase_r     <= phase_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    cnt_r      <= cnt_nxt;
    lit_r      <= lit_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_end_r;

  `ASSERT_NEXT(a_count_bound, emit_go, bw_r <= len_r, "byte count passed output length")
  `ASSERT_CLK(a_emit_after_read,
    state_r == S_EMIT |-> ($past(state_r) == S_RD || $past(state_r) == S_EMIT),
    "copy emit without ring read")
  `ASSERT_CLK(a_end_is_last, out_valid_r && out_end_r |-> out_last_r,
    "stream end without run last")
  `ASSERT_CLK(a_run_nonzero, state_r == S_RD |-> cnt_r != '0, "ring read with empty run")

endmodule

`default_nettype wire

### rtl/lzss_window_decoder_unit.sv
// Sequence: flag and match-low bytes are taken in the idle state and give no item;
// a literal is stored, then emitted from the literal state into the output
// register; a match emits each byte through a ring read state, then an emit state.
// Throughput is bound by the single read port of the history ring.
// Reset (rst_n, synchronous) clears parse state, byte count, output length
// and the output valid flag; the history ring and output data are not cleared.
// ---------------------------------------------------------------------------
// LZSS window decoder unit
// Top level: decodes an LZSS byte stream against a 4 KiB history ring.
// ---------------------------------------------------------------------------
`default_nettype none

module lzss_window_decoder_unit
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_SIZE = LZSSWD_WINDOW_SIZE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,   // output_length
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // code_byte
  input  wire logic [0:0]  in_tuser,      // stream_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // data_byte
  output logic             out_tlast,     // run_last
  output logic [0:0]       out_tuser      // stream_end
);

  lzsswd_core #(.WINDOW_SIZE(WINDOW_SIZE)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

### tb/lzss_window_decoder_unit_tb.sv
// ---------------------------------------------------------------------------
// LZSS window decoder unit testbench
// Feeds compressed byte streams into the decoder and checks every decoded
// byte, with its last and end marks, against a predictor that tracks its
// own copy of the history ring and the parse state. Runs a short directed
// part, then random streams under several sender and receiver idle patterns
// and output lengths, including a long receiver hold-off.
// ---------------------------------------------------------------------------
module lzss_window_decoder_unit_tb;
  import lzsswd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 110;

  typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_MATCH_HIGH} parse_phase_t;

  typedef struct packed {
    bit       start;
    bit [7:0] code;
  } code_item_t;

  typedef struct packed {
    bit [7:0] data;
    bit       last;
    bit       fin;
  } decoded_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic [0:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  lzss_window_decoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // decoder predictor state
  bit [7:0]     ring_copy [LZSSWD_WINDOW_SIZE];
  count_t       dec_count = '0;
  count_t       dec_len   = '0;
  bit [8:0]     dec_flags = '0;
  parse_phase_t dec_phase = PH_FLAG;
  bit [7:0]     dec_low   = '0;

  decoded_t   exp_bytes  [$];
  code_item_t pend_codes [$];
  code_item_t cur_item;
  decoded_t   want;

  int gen_cnt        = 0;
  int n_pushed       = 0;
  int n_in           = 0;
  int n_checked      = 0;
  int n_err          = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go        = 1'b0;
  bit rx_hold        = 1'b0;

  function automatic void emit_byte(bit [7:0] v, bit last);
    ring_copy[dec_count[11:0]] = v;
    dec_count = dec_count + 1'b1;
    exp_bytes.push_back('{v, last, dec_count == dec_len});
  endfunction

  function automatic void shift_flags();
    dec_flags = dec_flags >> 1;
    dec_phase = (dec_flags < 2) ? PH_FLAG : PH_ITEM;
  endfunction

  function automatic void predict_code(bit start, bit [7:0] b);
    bit [11:0]   pos;
    int unsigned back_dist;
    int unsigned run;
    bit [7:0]    v;
    if (start) begin
      dec_count = '0;
      dec_flags = '0;
      dec_phase = PH_FLAG;
      dec_low   = '0;
    end
    if (dec_count >= dec_len) return;
    case (dec_phase)
      PH_ITEM: begin
        if (dec_flags[0]) begin
          emit_byte(b, 1'b1);
          shift_flags();
        end else begin
          dec_low   = b;
          dec_phase = PH_MATCH_HIGH;
        end
      end
      PH_MATCH_HIGH: begin
        pos       = {b[7:4], dec_low} + MATCH_BIAS;
        back_dist = 12'(dec_count[11:0] - pos);
        if (back_dist == 0) back_dist = LZSSWD_WINDOW_SIZE;
        run = b[3:0] + MIN_MATCH;
        if (run > dec_len - dec_count) run = dec_len - dec_count;
        for (int unsigned i = 0; i < run; i++) begin
          v = (dec_count >= back_dist) ? ring_copy[12'(dec_count - back_dist)] : 8'h00;
          emit_byte(v, i + 1 == run);
        end
        shift_flags();
      end
      default: begin
        dec_flags = FLAG_MARK | b;
        dec_phase = PH_ITEM;
      end
    endcase
  endfunction

  // stream builders
  function automatic void push_raw(bit start, bit [7:0] b);
    pend_codes.push_back('{start, b});
    n_pushed++;
  endfunction

  function automatic void push_flag(bit start, bit [7:0] f);
    if (start) gen_cnt = 0;
    push_raw(start, f);
  endfunction

  function automatic void push_lit(bit [7:0] b);
    push_raw(1'b0, b);
    gen_cnt++;
  endfunction

  function automatic void push_match(int back, int len);
    bit [11:0] pos;
    pos = 12'(gen_cnt - back) - MATCH_BIAS;
    push_raw(1'b0, pos[7:0]);
    push_raw(1'b0, {pos[11:8], 4'(len - int'(MIN_MATCH))});
    gen_cnt += len;
  endfunction

  function automatic void gen_stream(bit restart);
    bit [7:0] flags;
    int       span;
    flags = 8'($urandom);
    push_flag(restart, flags);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(19) == 0) return;
      if ($urandom_range(15) == 0) begin
        push_raw($urandom_range(15) == 0, 8'($urandom));
      end else if (flags[i]) begin
        push_lit(8'($urandom));
      end else begin
        span = (gen_cnt < 1) ? 1 :
               (gen_cnt > LZSSWD_WINDOW_SIZE ? LZSSWD_WINDOW_SIZE : gen_cnt);
        if ($urandom_range(7) == 0) span = LZSSWD_WINDOW_SIZE;
        push_match($urandom_range(1, span), $urandom_range(3, 18));
      end
    end
  endfunction

  function automatic void check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_code(cur_item.start, cur_item.code);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pend_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pend_codes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_item.code;
          in_tuser  <= cur_item.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (exp_bytes.size() == 0) begin
        n_err++;
        $display("%0t: unexpected item, expected none, got data %h last %b end %b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = exp_bytes.pop_front();
        check_field("data_byte", want.data, out_tdata);
        check_field("run_last", want.last, out_tlast);
        check_field("stream_end", want.fin, out_tuser);
      end
    end
  end

  // receiver hold-off
  initial begin
    wait (hold_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d items still expected", $time, exp_bytes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_codes.size() != 0 || in_tvalid || exp_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_len(count_t v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    dec_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, count_t len, bit with_hold);
    int stop_at;
    set_len(len);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = n_pushed + PHASE_ITEMS;
    gen_stream(1'b1);
    while (n_pushed < stop_at) gen_stream($urandom_range(2) == 0);
    if (with_hold) hold_go = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero length: everything dropped
    set_len('0);
    push_flag(1'b1, 8'hFF);
    push_lit(8'h12);
    push_lit(8'h34);
    wait_idle();

    // literals, overlapping copy, reads ahead of stream start, clamp at end
    set_len(24'd30);
    push_flag(1'b1, 8'b1010_0110);
    push_match(5, 3);
    push_lit(8'h00);
    push_lit(8'hFF);
    push_match(2, 18);
    push_match(LZSSWD_WINDOW_SIZE, 4);
    push_lit(8'h5A);
    push_raw(1'b0, 8'hFF);
    push_raw(1'b0, 8'hFF);
    push_lit(8'h77);
    push_flag(1'b1, 8'h0F);
    push_lit(8'h00);
    push_lit(8'hFF);
    push_lit(8'h80);
    push_lit(8'h01);
    wait_idle();

    // length lowered below the count: drop the rest
    set_len(24'd2);
    push_raw(1'b0, 8'hC3);
    push_raw(1'b0, 8'h3C);
    wait_idle();

    // one-byte stream clamps a long match
    set_len(24'd1);
    push_flag(1'b1, 8'h00);
    push_match(1, 18);
    wait_idle();

    run_phase(0, 0, 24'hFF_FFFF, 1'b0);
    run_phase(76, 0, 24'($urandom_range(20, 400)), 1'b0);
    run_phase(0, 76, 24'($urandom_range(1000, 5000)), 1'b1);
    run_phase(34, 34, 24'($urandom_range(1, 60)), 1'b0);

    $display("Covered %0d code items and %0d decoded bytes, lengths 0 to 16777215,",
             n_in, n_checked);
    $display("with sender gaps, receiver stalls and a %0d-cycle hold-off.", HOLD_CYCLES);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
